FILE: rtl/core/dpc_pkg.sv
// Shared types and constants for the depth pixel to color point core.
// Used by dpc_div, depth_pixel_to_color_point_core and tb_top; no dependencies.
package dpc_pkg;

  // Field widths of the pixel stream
  localparam int DEPTH_FRACTION_BITS = 24;
  localparam int PIXEL_INDEX_BITS    = 12;

  // Divider datapath widths
  localparam int QUOT_W  = 32;
  localparam int REM_W   = 64;
  localparam int SIDE_W  = 64;
  localparam int PROD_W  = 96;
  localparam int DEPTH_SHIFT = DEPTH_FRACTION_BITS - 16;
  localparam int DIVD_W  = PROD_W + DEPTH_SHIFT;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_NEAR_PLANE    = 3'd0,
    REG_FAR_PLANE     = 3'd1,
    REG_SCENE_EXTENT  = 3'd2,
    REG_FOCAL_LENGTH  = 3'd3,
    REG_CENTER_COLUMN = 3'd4,
    REG_CENTER_ROW    = 3'd5
  } cfg_reg_t;

  // One stage of the restoring divider
  typedef struct packed {
    logic              valid;
    logic              big;
    logic [REM_W-1:0]  rem;
    logic [QUOT_W-1:0] num;
    logic [REM_W-1:0]  den;
    logic [QUOT_W-1:0] quot;
    logic [SIDE_W-1:0] side;
  } div_stage_t;

  // Side data through the depth divider
  typedef struct packed {
    logic [PIXEL_INDEX_BITS-1:0] row;
    logic [PIXEL_INDEX_BITS-1:0] col;
    logic [7:0]                  red;
    logic [7:0]                  green;
    logic [7:0]                  blue;
  } z_side_t;

  // Side data through the projection dividers
  typedef struct packed {
    logic [31:0] z;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        neg_x;
    logic        neg_y;
    logic        zero_x;
    logic        zero_y;
  } p_side_t;

endpackage

FILE: rtl/core/dpc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on dpc_pkg for the stage structure and widths.
module dpc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  dpc_pkg::div_stage_t in_stage,
  output dpc_pkg::div_stage_t out_stage
);

  dpc_pkg::div_stage_t st [0:dpc_pkg::QUOT_W];
  dpc_pkg::div_stage_t nxt [0:dpc_pkg::QUOT_W-1];

  // Capture the operands
  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else if (en) begin
      st[0].valid <= in_stage.valid;
    end
    if (en) begin
      st[0].big  <= in_stage.big;
      st[0].rem  <= in_stage.rem;
      st[0].num  <= in_stage.num;
      st[0].den  <= in_stage.den;
      st[0].quot <= in_stage.quot;
      st[0].side <= in_stage.side;
    end
  end

  genvar i;
  generate
    for (i = 0; i < dpc_pkg::QUOT_W; i++) begin : g_step
      logic [dpc_pkg::REM_W:0] shifted;
      logic                    ge;

      // Shift in one dividend bit, subtract where it fits
      always_comb begin
        shifted = {st[i].rem, st[i].num[dpc_pkg::QUOT_W-1]};
        ge      = shifted >= {1'b0, st[i].den};
        nxt[i]  = st[i];
        nxt[i].rem  = ge ? dpc_pkg::REM_W'(shifted - {1'b0, st[i].den})
                         : shifted[dpc_pkg::REM_W-1:0];
        nxt[i].num  = {st[i].num[dpc_pkg::QUOT_W-2:0], 1'b0};
        nxt[i].quot = {st[i].quot[dpc_pkg::QUOT_W-2:0], ge};
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          st[i+1].valid <= 1'b0;
        end else if (en) begin
          st[i+1].valid <= nxt[i].valid;
        end
        if (en) begin
          st[i+1].big  <= nxt[i].big;
          st[i+1].rem  <= nxt[i].rem;
          st[i+1].num  <= nxt[i].num;
          st[i+1].den  <= nxt[i].den;
          st[i+1].quot <= nxt[i].quot;
          st[i+1].side <= nxt[i].side;
        end
      end
    end
  endgenerate

  assign out_stage = st[dpc_pkg::QUOT_W];

endmodule

FILE: rtl/core/depth_pixel_to_color_point_core.sv
// Depth pixel to colored 3D point: linearize depth, back-project through a pinhole.
// Depends on dpc_pkg and dpc_div.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------
//   in      | input     | in_valid / in_stall   | raw_depth, pixel_row/column, rgb
//   out     | output    | out_valid / out_stall | point_x/y/z, rgb
//   cfg     | input     | cfg_write             | cfg_index, cfg_data
//
// One pixel enters per cycle while the output is not stalled; the pipeline is the two 33-stage
// bit-per-stage dividers (depth, then x/y projection) and seven arithmetic stages.
// Dropped pixels leave a bubble and produce no transfer.
// Synchronous reset clears all valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
module depth_pixel_to_color_point_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [dpc_pkg::DEPTH_FRACTION_BITS-1:0] raw_depth,
  input  logic [dpc_pkg::PIXEL_INDEX_BITS-1:0]  pixel_row,
  input  logic [dpc_pkg::PIXEL_INDEX_BITS-1:0]  pixel_column,
  input  logic [7:0]                            red_in,
  input  logic [7:0]                            green_in,
  input  logic [7:0]                            blue_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [31:0]                    point_x,
  output logic signed [31:0]                    point_y,
  output logic [31:0]                           point_z,
  output logic [7:0]                            red_out,
  output logic [7:0]                            green_out,
  output logic [7:0]                            blue_out,
  input  logic                                  cfg_write,
  input  logic [2:0]                            cfg_index,
  input  logic [31:0]                           cfg_data
);

  localparam int DFB = dpc_pkg::DEPTH_FRACTION_BITS;
  localparam int PIB = dpc_pkg::PIXEL_INDEX_BITS;
  localparam int PX_W = PIB + 32;

  logic [31:0]    near_plane, far_plane, scene_extent, focal_length;
  logic [PIB-1:0] center_column, center_row;
  logic           en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      near_plane    <= 32'd655;
      far_plane     <= 32'd3276800;
      scene_extent  <= 32'd65536;
      focal_length  <= 32'd37971558;
      center_column <= PIB'(320);
      center_row    <= PIB'(240);
    end else if (cfg_write) begin
      case (dpc_pkg::cfg_reg_t'(cfg_index))
        dpc_pkg::REG_NEAR_PLANE:    near_plane    <= cfg_data;
        dpc_pkg::REG_FAR_PLANE:     far_plane     <= cfg_data;
        dpc_pkg::REG_SCENE_EXTENT:  scene_extent  <= cfg_data;
        dpc_pkg::REG_FOCAL_LENGTH:  focal_length  <= cfg_data;
        dpc_pkg::REG_CENTER_COLUMN: center_column <= cfg_data[PIB-1:0];
        dpc_pkg::REG_CENTER_ROW:    center_row    <= cfg_data[PIB-1:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances unless the output holds a stalled result
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 1: capture pixel
  logic           s1_valid;
  logic [DFB-1:0] s1_d;
  dpc_pkg::z_side_t s1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_d          <= raw_depth;
      s1_side.row   <= pixel_row;
      s1_side.col   <= pixel_column;
      s1_side.red   <= red_in;
      s1_side.green <= green_in;
      s1_side.blue  <= blue_in;
    end
  end

  // Stage 2: near*far, and the two denominator products
  logic                s2_valid;
  logic [63:0]         s2_nf;
  logic [32+DFB:0]     s2_fd;
  logic [31+DFB:0]     s2_nd;
  dpc_pkg::z_side_t    s2_side;
  logic [DFB:0]        one_minus_d;

  assign one_minus_d = {1'b1, {DFB{1'b0}}} - {1'b0, s1_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      s2_nf   <= near_plane * far_plane;
      s2_fd   <= far_plane * one_minus_d;
      s2_nd   <= near_plane * s1_d;
      s2_side <= s1_side;
    end
  end

  // Stage 3: denominator sum, numerator partial products
  logic             s3_valid;
  logic [63:0]      s3_den, s3_plo, s3_phi;
  dpc_pkg::z_side_t s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
    if (en) begin
      s3_den  <= 64'(s2_fd) + 64'(s2_nd);
      s3_plo  <= s2_nf[31:0] * scene_extent;
      s3_phi  <= s2_nf[63:32] * scene_extent;
      s3_side <= s2_side;
    end
  end

  // Stage 4: combine numerator, align to the depth fraction
  logic                         s4_valid;
  logic [dpc_pkg::DIVD_W-1:0]   s4_divd;
  logic [63:0]                  s4_den;
  dpc_pkg::z_side_t             s4_side;
  logic [dpc_pkg::PROD_W-1:0]   prod96;

  assign prod96 = {32'd0, s3_plo} + {s3_phi, 32'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
    if (en) begin
      s4_divd <= dpc_pkg::DIVD_W'(prod96) << dpc_pkg::DEPTH_SHIFT;
      s4_den  <= s3_den;
      s4_side <= s3_side;
    end
  end

  // Depth divider; a high part not below the denominator saturates z
  dpc_pkg::div_stage_t       zd_in, zd_out;
  logic [dpc_pkg::DIVD_W-33:0] z_hi;

  assign z_hi = s4_divd[dpc_pkg::DIVD_W-1:32];

  always_comb begin
    zd_in.valid = s4_valid;
    zd_in.big   = z_hi >= (dpc_pkg::DIVD_W-32)'(s4_den);
    zd_in.rem   = z_hi[63:0];
    zd_in.num   = s4_divd[31:0];
    zd_in.den   = s4_den;
    zd_in.quot  = '0;
    zd_in.side  = dpc_pkg::SIDE_W'(s4_side);
  end

  dpc_div u_zdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_stage (zd_in),
    .out_stage(zd_out)
  );

  // Stage A: saturate z, cull at far plane, pixel offsets
  dpc_pkg::z_side_t zo_side;
  logic [31:0]      z_sat;
  logic             a_valid, a_drop, a_neg_x, a_neg_y;
  logic [31:0]      a_z;
  logic [PIB-1:0]   a_mag_x, a_mag_y;
  logic [7:0]       a_red, a_green, a_blue;

  assign zo_side = dpc_pkg::z_side_t'(zd_out.side[$bits(dpc_pkg::z_side_t)-1:0]);
  assign z_sat   = zd_out.big ? 32'hFFFF_FFFF : zd_out.quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= zd_out.valid;
    end
    if (en) begin
      a_z     <= z_sat;
      a_drop  <= z_sat >= far_plane;
      a_neg_x <= zo_side.col < center_column;
      a_neg_y <= zo_side.row < center_row;
      a_mag_x <= (zo_side.col < center_column) ? center_column - zo_side.col
                                               : zo_side.col - center_column;
      a_mag_y <= (zo_side.row < center_row) ? center_row - zo_side.row
                                            : zo_side.row - center_row;
      a_red   <= zo_side.red;
      a_green <= zo_side.green;
      a_blue  <= zo_side.blue;
    end
  end

  // Stage B: offset times depth
  logic            b_valid;
  logic [PX_W-1:0] b_px, b_py;
  dpc_pkg::p_side_t b_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid && !a_drop;
    end
    if (en) begin
      b_px         <= a_mag_x * a_z;
      b_py         <= a_mag_y * a_z;
      b_side.z     <= a_z;
      b_side.red   <= a_red;
      b_side.green <= a_green;
      b_side.blue  <= a_blue;
      b_side.neg_x <= a_neg_x;
      b_side.neg_y <= a_neg_y;
      b_side.zero_x <= (a_mag_x == '0) || (a_z == '0);
      b_side.zero_y <= (a_mag_y == '0) || (a_z == '0);
    end
  end

  // Projection dividers: (product << 16) / focal length
  dpc_pkg::div_stage_t xd_in, xd_out, yd_in, yd_out;

  always_comb begin
    xd_in.valid = b_valid;
    xd_in.big   = 32'(b_px[PX_W-1:16]) >= focal_length;
    xd_in.rem   = 64'(b_px[PX_W-1:16]);
    xd_in.num   = {b_px[15:0], 16'd0};
    xd_in.den   = 64'(focal_length);
    xd_in.quot  = '0;
    xd_in.side  = dpc_pkg::SIDE_W'(b_side);
    yd_in       = xd_in;
    yd_in.big   = 32'(b_py[PX_W-1:16]) >= focal_length;
    yd_in.rem   = 64'(b_py[PX_W-1:16]);
    yd_in.num   = {b_py[15:0], 16'd0};
    yd_in.side  = '0;
  end

  dpc_div u_xdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_stage (xd_in),
    .out_stage(xd_out)
  );

  dpc_div u_ydiv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_stage (yd_in),
    .out_stage(yd_out)
  );

  // Signed saturation of a projected coordinate
  function automatic logic [31:0] proj_sat(logic neg, logic zero, logic big,
                                           logic [31:0] q);
    logic [31:0] r;
    if (zero) begin
      r = '0;
    end else if (neg) begin
      r = (big || q > 32'h8000_0000) ? 32'h8000_0000 : 32'd0 - q;
    end else begin
      r = (big || q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
    end
    return r;
  endfunction

  // Output register
  dpc_pkg::p_side_t po_side;
  assign po_side = dpc_pkg::p_side_t'(xd_out.side[$bits(dpc_pkg::p_side_t)-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= xd_out.valid;
    end
    if (en) begin
      point_x   <= proj_sat(po_side.neg_x, po_side.zero_x, xd_out.big, xd_out.quot);
      point_y   <= proj_sat(po_side.neg_y, po_side.zero_y, yd_out.big, yd_out.quot);
      point_z   <= po_side.z;
      red_out   <= po_side.red;
      green_out <= po_side.green;
      blue_out  <= po_side.blue;
    end
  end

  // Checks
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(point_z)))
    else $error("stalled result lost");
  a_cull_far: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (b_side.z < far_plane))
    else $error("point beyond far plane kept");
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    xd_out.valid == yd_out.valid)
    else $error("projection dividers out of step");

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for depth_pixel_to_color_point_core: pixel stream in, points out.
// Depends on dpc_pkg and the core RTL; predicts each point from its own model
// of the depth linearization and the pinhole back-projection.
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH_FRACTION_BITS = dpc_pkg::DEPTH_FRACTION_BITS;
  localparam int PIXEL_INDEX_BITS    = dpc_pkg::PIXEL_INDEX_BITS;
  localparam int DRAIN_CYCLES = 90;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [DEPTH_FRACTION_BITS-1:0] depth;
    logic [PIXEL_INDEX_BITS-1:0]    row;
    logic [PIXEL_INDEX_BITS-1:0]    col;
    logic [7:0]                     red;
    logic [7:0]                     green;
    logic [7:0]                     blue;
  } pixel_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [DEPTH_FRACTION_BITS-1:0] raw_depth = '0;
  logic [PIXEL_INDEX_BITS-1:0] pixel_row = '0;
  logic [PIXEL_INDEX_BITS-1:0] pixel_column = '0;
  logic [7:0] red_in = '0;
  logic [7:0] green_in = '0;
  logic [7:0] blue_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic [31:0] point_z;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Register shadow used by the point predictor
  logic [31:0] near_r, far_r, extent_r, focal_r;
  logic [PIXEL_INDEX_BITS-1:0] cx_r, cy_r;

  pixel_t pixel_q[$];
  point_t point_q[$];
  pixel_t cur_pixel;
  int pushed_cnt = 0;
  int accepted_cnt = 0;
  int mismatch_cnt = 0;
  int send_idle_pct = 7;
  int recv_idle_pct = 53;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;
  int quiet_cycles = 0;

  depth_pixel_to_color_point_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Linear depth in Q16.16, saturated; zero denominator saturates too
  function automatic logic [31:0] linear_z(logic [DEPTH_FRACTION_BITS-1:0] d);
    logic [63:0]  den;
    logic [127:0] num;
    logic [127:0] q;
    den = 64'(far_r) * ((64'd1 << DEPTH_FRACTION_BITS) - 64'(d)) + 64'(near_r) * 64'(d);
    num = (128'(near_r) * 128'(far_r) * 128'(extent_r)) << (DEPTH_FRACTION_BITS - 16);
    if (den == 0) return '1;
    q = num / 128'(den);
    return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  // Offset from the principal point times z over f, signed and saturated
  function automatic logic [31:0] project_axis(logic [PIXEL_INDEX_BITS-1:0] pix,
                                               logic [PIXEL_INDEX_BITS-1:0] center,
                                               logic [31:0] z);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] q;
    neg  = pix < center;
    mag  = neg ? 64'(center - pix) : 64'(pix - center);
    prod = mag * 64'(z);
    if (prod == 0) return '0;
    q = (focal_r == 0) ? (64'd1 << 40) : (prod << 16) / 64'(focal_r);
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'd0 - q[31:0];
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  task automatic predict_point(pixel_t p);
    point_t pt;
    pt.z = linear_z(p.depth);
    if (pt.z >= far_r) return;
    pt.x = project_axis(p.col, cx_r, pt.z);
    pt.y = project_axis(p.row, cy_r, pt.z);
    pt.red = p.red;
    pt.green = p.green;
    pt.blue = p.blue;
    point_q = {point_q, pt};
  endtask

  task automatic add_pixel(logic [DEPTH_FRACTION_BITS-1:0] d, logic [PIXEL_INDEX_BITS-1:0] r,
                           logic [PIXEL_INDEX_BITS-1:0] c, logic [7:0] cr, logic [7:0] cg,
                           logic [7:0] cb);
    pixel_t p;
    p = '{d, r, c, cr, cg, cb};
    pixel_q = {pixel_q, p};
    pushed_cnt++;
  endtask

  // Random pixels; depth leans toward the ends and small values now and then
  task automatic add_random(int n);
    logic [DEPTH_FRACTION_BITS-1:0] d;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0: d = DEPTH_FRACTION_BITS'($urandom_range(255));
        1: d = '1 - DEPTH_FRACTION_BITS'($urandom_range(255));
        default: d = DEPTH_FRACTION_BITS'($urandom);
      endcase
      add_pixel(d, PIXEL_INDEX_BITS'($urandom), PIXEL_INDEX_BITS'($urandom),
                8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      dpc_pkg::REG_NEAR_PLANE:    near_r = data;
      dpc_pkg::REG_FAR_PLANE:     far_r = data;
      dpc_pkg::REG_SCENE_EXTENT:  extent_r = data;
      dpc_pkg::REG_FOCAL_LENGTH:  focal_r = data;
      dpc_pkg::REG_CENTER_COLUMN: cx_r = data[PIXEL_INDEX_BITS-1:0];
      dpc_pkg::REG_CENTER_ROW:    cy_r = data[PIXEL_INDEX_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Wait for every pixel to go in and every point to come out, then let drops flush
  task automatic drain;
    while (accepted_cnt != pushed_cnt || point_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Driver: hold a stalled pixel, otherwise offer the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_point(cur_pixel);
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_pixel = pixel_q.pop_front();
          raw_depth <= cur_pixel.depth;
          pixel_row <= cur_pixel.row;
          pixel_column <= cur_pixel.col;
          red_in <= cur_pixel.red;
          green_in <= cur_pixel.green;
          blue_in <= cur_pixel.blue;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each point transfer with the oldest predicted point
  always @(posedge clk) begin
    point_t exp_pt;
    point_t got_pt;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_pt = '{point_x, point_y, point_z, red_out, green_out, blue_out};
        if (point_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected point %h", got_pt);
        end else begin
          exp_pt = point_q.pop_front();
          if (got_pt !== exp_pt) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("point mismatch: x %h/%h y %h/%h z %h/%h rgb %h/%h (exp/got)",
                       exp_pt.x, got_pt.x, exp_pt.y, got_pt.y, exp_pt.z, got_pt.z,
                       {exp_pt.red, exp_pt.green, exp_pt.blue},
                       {got_pt.red, got_pt.green, got_pt.blue});
          end
        end
      end
      // Long hold-off on request, random stall otherwise
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
        hold_ack <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    near_r = 32'd655;
    far_r = 32'd3276800;
    extent_r = 32'd65536;
    focal_r = 32'd37971558;
    cx_r = 12'd320;
    cy_r = 12'd240;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Defaults: depth ends, pixel index ends, principal point, color ends
    add_pixel('0, 12'd0, 12'd0, 8'h00, 8'hFF, 8'h00);
    add_pixel('1, 12'd4095, 12'd4095, 8'hFF, 8'h00, 8'hFF);
    add_pixel(24'h000001, 12'd240, 12'd320, 8'h55, 8'hAA, 8'h0F);
    add_pixel(24'h800000, 12'd0, 12'd4095, 8'hFF, 8'hFF, 8'hFF);
    add_pixel(24'hFFF000, 12'd4095, 12'd0, 8'h00, 8'h00, 8'h00);
    add_pixel(24'hFFFF00, 12'd239, 12'd321, 8'h80, 8'h01, 8'hFE);
    add_pixel(24'hFFFFF0, 12'd241, 12'd319, 8'h7F, 8'h10, 8'hEF);
    add_random(100);
    drain();

    // Random registers, near beyond far allowed; spare indexes ignored
    write_reg(dpc_pkg::REG_NEAR_PLANE, $urandom_range(32'h0010_0000));
    write_reg(dpc_pkg::REG_FAR_PLANE, $urandom_range(32'h0100_0000));
    write_reg(dpc_pkg::REG_SCENE_EXTENT, $urandom_range(32'h0004_0000));
    write_reg(dpc_pkg::REG_FOCAL_LENGTH, $urandom_range(32'h0400_0000, 32'h0001_0000));
    write_reg(dpc_pkg::REG_CENTER_COLUMN, 32'hFFFF_F000 | $urandom_range(4095));
    write_reg(dpc_pkg::REG_CENTER_ROW, 32'hABCD_E000 | $urandom_range(4095));
    write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_B, 32'h0000_0000);
    send_idle_pct = 53;
    recv_idle_pct = 7;
    add_random(100);
    drain();

    // Zero focal length: coordinates saturate toward the offset sign
    write_reg(dpc_pkg::REG_NEAR_PLANE, 32'd655);
    write_reg(dpc_pkg::REG_FAR_PLANE, 32'hFFFF_FFFF);
    write_reg(dpc_pkg::REG_SCENE_EXTENT, 32'd65536);
    write_reg(dpc_pkg::REG_FOCAL_LENGTH, 32'd0);
    write_reg(dpc_pkg::REG_CENTER_COLUMN, 32'd2048);
    write_reg(dpc_pkg::REG_CENTER_ROW, 32'd2048);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_pixel(24'h400000, 12'd2048, 12'd0, 8'h01, 8'h02, 8'h03);
    add_pixel(24'h400000, 12'd0, 12'd2048, 8'h04, 8'h05, 8'h06);
    add_pixel(24'h400000, 12'd4095, 12'd4095, 8'h07, 8'h08, 8'h09);
    add_random(20);
    @(posedge clk);
    hold_req <= ~hold_req;
    add_random(60);
    drain();

    // Extremes: huge near with unit focal length, coordinates overflow
    write_reg(dpc_pkg::REG_NEAR_PLANE, 32'hFFFF_FFFF);
    write_reg(dpc_pkg::REG_FAR_PLANE, 32'hFFFF_FFFF);
    write_reg(dpc_pkg::REG_SCENE_EXTENT, 32'd1);
    write_reg(dpc_pkg::REG_FOCAL_LENGTH, 32'd1);
    write_reg(dpc_pkg::REG_CENTER_COLUMN, 32'd4095);
    write_reg(dpc_pkg::REG_CENTER_ROW, 32'd0);
    add_pixel('0, 12'd4095, 12'd0, 8'hC3, 8'h3C, 8'h99);
    add_random(40);
    drain();

    // Zero far and near: zero denominator, every pixel dropped
    write_reg(dpc_pkg::REG_FAR_PLANE, 32'd0);
    write_reg(dpc_pkg::REG_NEAR_PLANE, 32'd0);
    add_pixel('0, 12'd1, 12'd1, 8'h11, 8'h22, 8'h33);
    add_pixel('1, 12'd2, 12'd2, 8'h44, 8'h55, 8'h66);
    drain();

    // Back to moderate values for a final random stretch
    write_reg(dpc_pkg::REG_NEAR_PLANE, 32'd6554);
    write_reg(dpc_pkg::REG_FAR_PLANE, 32'd6553600);
    write_reg(dpc_pkg::REG_SCENE_EXTENT, 32'd131072);
    write_reg(dpc_pkg::REG_FOCAL_LENGTH, 32'd32768000);
    write_reg(dpc_pkg::REG_CENTER_COLUMN, 32'd0);
    write_reg(dpc_pkg::REG_CENTER_ROW, 32'd4095);
    send_idle_pct = 25;
    recv_idle_pct = 25;
    add_random(60);
    drain();

    if (mismatch_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
